// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the stamp sorted id table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define STSI_ASSERT(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define STSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/stsi_pkg.sv
// Types, codes and sizes shared by the stamp sorted id table.
package stsi_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int STAMP_W     = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [ID_W-1:0]    sub_id;
    logic [STAMP_W-1:0] stamp;
  } stsi_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [STAMP_W-1:0] found_stamp;
    logic [CNT_W-1:0]   entry_count;
  } stsi_out_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } stsi_entry_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } stsi_ctrl_t;

endpackage

// File: rtl/stsi_cell.sv
// One table slot: holds an entry, compares it with a new transaction and shifts.
module stsi_cell (
  input  logic                           clk,
  input  stsi_pkg::stsi_ctrl_t           ctrl,
  input  stsi_pkg::stsi_in_t             cmp_cmd,
  input  stsi_pkg::stsi_entry_t          new_entry,
  input  logic                           head,
  input  logic                           occupied,
  input  logic                           at_count,
  input  stsi_pkg::stsi_entry_t          left_entry,
  input  logic                           left_shift,
  input  stsi_pkg::stsi_entry_t          right_entry,
  input  logic                           gap_in,
  output stsi_pkg::stsi_entry_t          entry,
  output logic                           shift,
  output logic                           match,
  output logic                           gap_out,
  output logic [stsi_pkg::STAMP_W-1:0]   hit_stamp
);
  import stsi_pkg::*;

  stsi_entry_t entry_r;
  stsi_entry_t entry_nxt;
  logic        match_r;
  logic        shift_r;
  logic        stamp_gt;
  logic        stamp_eq;

  assign stamp_gt = entry_r.stamp > cmp_cmd.stamp;
  assign stamp_eq = entry_r.stamp == cmp_cmd.stamp;

  // The head slot lets an equal stamp stay in front; later slots do not.
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match_r <= occupied && (entry_r.id == cmp_cmd.sub_id);
      shift_r <= occupied && (stamp_gt || (!head && stamp_eq));
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en) begin
      if (left_shift) begin
        entry_nxt = left_entry;
      end else if (shift_r || at_count) begin
        entry_nxt = new_entry;
      end
    end else if (ctrl.del_en && gap_out) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry     = entry_r;
  assign shift     = shift_r;
  assign match     = match_r;
  assign gap_out   = gap_in | match_r;
  assign hit_stamp = match_r ? entry_r.stamp : '0;

endmodule

// File: rtl/stamp_sorted_id_table_unit.sv
// Top level of the stamp sorted id table: a row of slots kept in stamp order.
//
// The table holds up to TABLE_DEPTH entries of id and time stamp in ascending
// stamp order, in a row of identical slots. Every transaction has a compare
// step and a shift step: in the cycle it is accepted, every slot compares its
// entry with the incoming id and stamp and registers the result; in the shift
// step, which waits until the output register is free, the slots act together,
// each loading the new entry, its left neighbor's entry on an insert or its
// right neighbor's entry on a delete, and the result is written to the output
// register. The input is ready again after the shift step, so the block takes
// no new transaction until the last one has shifted. A result waiting in the
// output register does not hold off the next transaction's acceptance and
// compare; only its shift step waits until the output register is free. A
// duplicate id wins over a full table, inserts after a head entry with an equal
// stamp, and the unused opcode returns ok with the count unchanged.
module stamp_sorted_id_table_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  stsi_pkg::stsi_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stsi_pkg::stsi_out_t  out_data
);
  import stsi_pkg::*;

  `include "assert_macros.svh"

  logic               busy_r;
  logic               busy_nxt;
  stsi_in_t           cmd_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  stsi_out_t          out_data_r;
  stsi_out_t          result;

  logic               accept;
  logic               exec;
  logic               any_match;
  logic               full;
  logic [STAMP_W-1:0] found_or;
  stsi_ctrl_t         ctrl;
  stsi_entry_t        new_entry;

  stsi_entry_t        entry_w [TABLE_DEPTH];
  stsi_entry_t        left_w  [TABLE_DEPTH];
  stsi_entry_t        right_w [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] shift_w;
  logic [TABLE_DEPTH-1:0] left_shift_w;
  logic [TABLE_DEPTH-1:0] match_w;
  logic [TABLE_DEPTH:0]   gap_w;
  logic [STAMP_W-1:0]     hit_w [TABLE_DEPTH];

  assign accept = in_valid && in_ready;
  // The shift step runs once the output register can take the result.
  assign exec   = busy_r && (!out_valid_r || out_ready);

  assign any_match = |match_w;
  assign full      = count_r == CNT_W'(TABLE_DEPTH);
  assign new_entry = '{id: cmd_r.sub_id, stamp: cmd_r.stamp};

  assign ctrl.cmp_en = accept;
  assign ctrl.ins_en = exec && (cmd_r.opcode == OP_INSERT) && !any_match && !full;
  assign ctrl.del_en = exec && (cmd_r.opcode == OP_DELETE) && any_match;

  assign gap_w[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i]       = entry_w[i];
      assign left_shift_w[i] = 1'b0;
    end else begin : g_inner
      assign left_w[i]       = entry_w[i-1];
      assign left_shift_w[i] = shift_w[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_w[i] = entry_w[i];
    end else begin : g_body
      assign right_w[i] = entry_w[i+1];
    end

    stsi_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .cmp_cmd     (in_data),
      .new_entry   (new_entry),
      .head        (i == 0),
      .occupied    (CNT_W'(i) < count_r),
      .at_count    (CNT_W'(i) == count_r),
      .left_entry  (left_w[i]),
      .left_shift  (left_shift_w[i]),
      .right_entry (right_w[i]),
      .gap_in      (gap_w[i]),
      .entry       (entry_w[i]),
      .shift       (shift_w[i]),
      .match       (match_w[i]),
      .gap_out     (gap_w[i+1]),
      .hit_stamp   (hit_w[i])
    );
  end

  // Ids are unique, so at most one slot contributes a stamp.
  always_comb begin
    found_or = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found_or = found_or | hit_w[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.del_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    result = '{status: ST_OK, found_stamp: '0, entry_count: count_nxt};
    unique case (cmd_r.opcode)
      OP_INSERT: begin
        if (any_match) begin
          result.status = ST_DUP;
        end else if (full) begin
          result.status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (!any_match) begin
          result.status = ST_MISSING;
        end
      end
      OP_LOOKUP: begin
        if (any_match) begin
          result.found_stamp = found_or;
        end else begin
          result.status = ST_MISSING;
        end
      end
      default: begin
        result.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (exec) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data;
    end
    if (exec) begin
      out_data_r <= result;
    end
  end

  assign in_ready  = !busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `STSI_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(TABLE_DEPTH), "count exceeds depth")
  `STSI_ASSERT(a_unique_ids, clk, rst_n, !busy_r || $onehot0(match_w), "id held in two slots")
  `STSI_ASSERT_NEXT(a_insert_count, clk, rst_n, ctrl.ins_en, count_r == $past(count_r) + CNT_W'(1), "insert did not grow count")
  `STSI_ASSERT_NEXT(a_exec_result, clk, rst_n, exec, out_valid_r && (out_data_r.entry_count == count_r), "result count mismatch")

endmodule
